// ===== design/ilst_pkg.sv =====
`default_nettype none

package ilst_pkg;

  localparam int unsigned ActionWidth = 3;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [ActionWidth-1:0] {
    ACT_READ   = 3'd0,
    ACT_FRONT  = 3'd1,
    ACT_APPEND = 3'd2,
    ACT_BEFORE = 3'd3,
    ACT_DELETE = 3'd4
  } action_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation class kept for the duration of one request.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_INSERT,
    OP_DELETE
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_PLACE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_SLOT,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_t;

  typedef enum logic {
    WR_K,
    WR_SLOT
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    k_dec;
    logic    k_inc;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic up_more;
    logic dn_more;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/ilst_ctrl.sv =====
`default_nettype none

module ilst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire ilst_pkg::sts_t sts,
  output logic               busy,
  output ilst_pkg::cmd_t     cmd
);

  ilst_pkg::state_t state_r;
  ilst_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ilst_pkg::S_IDLE: begin
        if (start) state_nxt = ilst_pkg::S_DECODE;
      end
      ilst_pkg::S_DECODE: begin
        unique case (sts.op)
          ilst_pkg::OP_INSERT: state_nxt = ilst_pkg::S_UP_RD;
          ilst_pkg::OP_DELETE: state_nxt = ilst_pkg::S_DN_RD;
          default:             state_nxt = ilst_pkg::S_FINISH;
        endcase
      end
      ilst_pkg::S_UP_RD: begin
        state_nxt = sts.up_more ? ilst_pkg::S_UP_WR : ilst_pkg::S_PLACE;
      end
      ilst_pkg::S_UP_WR:  state_nxt = ilst_pkg::S_UP_RD;
      ilst_pkg::S_DN_RD: begin
        state_nxt = sts.dn_more ? ilst_pkg::S_DN_WR : ilst_pkg::S_FINISH;
      end
      ilst_pkg::S_DN_WR:  state_nxt = ilst_pkg::S_DN_RD;
      ilst_pkg::S_PLACE:  state_nxt = ilst_pkg::S_FINISH;
      ilst_pkg::S_FINISH: state_nxt = ilst_pkg::S_IDLE;
      default:            state_nxt = ilst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = ilst_pkg::RD_SLOT;
    cmd.wr_sel = ilst_pkg::WR_K;
    busy       = (state_r != ilst_pkg::S_IDLE);
    unique case (state_r)
      ilst_pkg::S_IDLE: begin
        cmd.load = start;
      end
      ilst_pkg::S_DECODE: begin
        cmd.rd_en  = (sts.op == ilst_pkg::OP_READ);
        cmd.rd_sel = ilst_pkg::RD_SLOT;
      end
      ilst_pkg::S_UP_RD: begin
        cmd.rd_en  = sts.up_more;
        cmd.rd_sel = ilst_pkg::RD_BELOW;
      end
      ilst_pkg::S_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ilst_pkg::WR_K;
        cmd.k_dec  = 1'b1;
      end
      ilst_pkg::S_DN_RD: begin
        cmd.rd_en  = sts.dn_more;
        cmd.rd_sel = ilst_pkg::RD_ABOVE;
      end
      ilst_pkg::S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ilst_pkg::WR_K;
        cmd.k_inc  = 1'b1;
      end
      ilst_pkg::S_PLACE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ilst_pkg::WR_SLOT;
      end
      ilst_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ilst_dp.sv =====
`default_nettype none

module ilst_dp #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 16,
  localparam int unsigned CntW       = $clog2(CAPACITY + 1),
  localparam int unsigned AddrW      = $clog2(CAPACITY)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ilst_pkg::cmd_t               cmd,
  output ilst_pkg::sts_t                    sts,
  input  wire logic [ilst_pkg::ActionWidth-1:0] in_action,
  input  wire logic [CntW-1:0]              in_position,
  input  wire logic [VALUE_WIDTH-1:0]       in_item_value,
  output logic                              out_valid,
  output logic [VALUE_WIDTH-1:0]            out_read_value,
  output logic [ilst_pkg::StatusWidth-1:0]  out_status,
  output logic [CntW-1:0]                   out_length_now
);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  ilst_pkg::op_t          op_r;
  logic [CntW-1:0]        cnt_r;
  logic [CntW-1:0]        slot_r;
  logic [CntW-1:0]        k_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] rdata_r;
  ilst_pkg::status_t      stat_r;
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_read_value_r;
  ilst_pkg::status_t      out_status_r;
  logic [CntW-1:0]        out_length_r;

  ilst_pkg::op_t          op_nxt;
  logic [CntW-1:0]        slot_nxt;
  ilst_pkg::status_t      stat_nxt;
  logic [CntW-1:0]        cnt_nxt;
  logic                   full;
  logic [CntW-1:0]        rd_addr;
  logic [CntW-1:0]        wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [CntW:0]          k_plus1;

  assign full = (cnt_r == CntW'(CAPACITY));

  // Request decode: range checks come before the full check for insert-before.
  always_comb begin
    op_nxt   = ilst_pkg::OP_NONE;
    slot_nxt = in_position;
    stat_nxt = ilst_pkg::ST_DONE;
    unique case (ilst_pkg::action_t'(in_action))
      ilst_pkg::ACT_READ: begin
        if (in_position < cnt_r) op_nxt = ilst_pkg::OP_READ;
        else stat_nxt = ilst_pkg::ST_RANGE;
      end
      ilst_pkg::ACT_FRONT: begin
        slot_nxt = '0;
        if (full) stat_nxt = ilst_pkg::ST_FULL;
        else op_nxt = ilst_pkg::OP_INSERT;
      end
      ilst_pkg::ACT_APPEND: begin
        slot_nxt = cnt_r;
        if (full) stat_nxt = ilst_pkg::ST_FULL;
        else op_nxt = ilst_pkg::OP_INSERT;
      end
      ilst_pkg::ACT_BEFORE: begin
        if (in_position > cnt_r) stat_nxt = ilst_pkg::ST_RANGE;
        else if (full) stat_nxt = ilst_pkg::ST_FULL;
        else op_nxt = ilst_pkg::OP_INSERT;
      end
      ilst_pkg::ACT_DELETE: begin
        if (in_position >= cnt_r) stat_nxt = ilst_pkg::ST_RANGE;
        else op_nxt = ilst_pkg::OP_DELETE;
      end
      default: begin
        op_nxt = ilst_pkg::OP_NONE;
      end
    endcase
  end

  assign k_plus1     = {1'b0, k_r} + (CntW+1)'(1);
  assign sts.op      = op_r;
  assign sts.up_more = (k_r > slot_r);
  assign sts.dn_more = (k_plus1 < {1'b0, cnt_r});

  always_comb begin
    unique case (op_r)
      ilst_pkg::OP_INSERT: cnt_nxt = cnt_r + CntW'(1);
      ilst_pkg::OP_DELETE: cnt_nxt = cnt_r - CntW'(1);
      default:             cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    unique case (cmd.rd_sel)
      ilst_pkg::RD_BELOW: rd_addr = k_r - CntW'(1);
      ilst_pkg::RD_ABOVE: rd_addr = k_plus1[CntW-1:0];
      default:            rd_addr = slot_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      ilst_pkg::WR_SLOT: begin
        wr_addr = slot_r;
        wr_data = val_r;
      end
      default: begin
        wr_addr = k_r;
        wr_data = rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr[AddrW-1:0]] <= wr_data;
    if (cmd.rd_en) rdata_r <= mem[rd_addr[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= ilst_pkg::OP_NONE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.load) op_r <= op_nxt;
      if (cmd.finish) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r <= slot_nxt;
      stat_r <= stat_nxt;
      val_r  <= in_item_value;
      k_r    <= (op_nxt == ilst_pkg::OP_INSERT) ? cnt_r : slot_nxt;
    end else if (cmd.k_dec) begin
      k_r <= k_r - CntW'(1);
    end else if (cmd.k_inc) begin
      k_r <= k_plus1[CntW-1:0];
    end
    if (cmd.finish) begin
      out_read_value_r <= (op_r == ilst_pkg::OP_READ) ? rdata_r : '0;
      out_status_r     <= stat_r;
      out_length_r     <= cnt_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_length_now = out_length_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> rd_addr < cnt_r)
    else $error("memory read outside the stored elements");

  a_valid_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.finish))
    else $error("result strobe without a finished request");

  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ilst_pkg::ST_DONE) |-> out_length_r == cnt_r)
    else $error("failed request changed the length");

endmodule

`default_nettype wire

// ===== design/indexed_list_store.sv =====
// Ordered list store: keeps up to CAPACITY values of VALUE_WIDTH bits and a
// current length. A request is transferred at a rising edge with start high
// and busy low; it carries in_action (read, insert front, append, insert
// before in_position, delete at in_position), in_position and in_item_value.
// Each request gives exactly one result: out_valid is high for one cycle
// with out_read_value, out_status (done, out of range, full) and
// out_length_now. The receiver cannot stall; results are never held back.
// Steps from the transfer edge to the result, n the length before:
//   read or failed request : decode, finish
//   insert at slot s       : decode, shift n - s elements up, place, finish
//   delete at slot s       : decode, shift n - 1 - s elements down, finish
// Every moved element costs one read and one write on the single memory
// port pair; that shift loop sets how long a request takes. A new request
// can be transferred in the cycle in which the previous result is shown.
// Reset clears the length to zero and drops any request in flight; stored
// values are not cleared and are never read before they are written.
`default_nettype none

module indexed_list_store #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 16,
  localparam int unsigned CntW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [ilst_pkg::ActionWidth-1:0]     in_action,
  input  wire logic [CntW-1:0]                      in_position,
  input  wire logic [VALUE_WIDTH-1:0]               in_item_value,
  output logic                                      out_valid,
  output logic [VALUE_WIDTH-1:0]                    out_read_value,
  output logic [ilst_pkg::StatusWidth-1:0]          out_status,
  output logic [CntW-1:0]                           out_length_now
);

  ilst_pkg::cmd_t cmd;
  ilst_pkg::sts_t sts;

  ilst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  ilst_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length_now (out_length_now)
  );

endmodule

`default_nettype wire
